>>> src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and response types, field widths and status codes shared by the
// queue top level and its storage cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Widths of the request and response fields on the channels.
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    // Request kinds.
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req_type;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One request on the input channel.
    typedef struct packed {
        t_req_type          req_type;
        logic [TAG_W-1:0]   payload;
        logic [PRIO_W-1:0]  priority_req;
    } t_spq_req;

    // One response on the output channel.
    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   out_payload;
        logic [PRIO_W-1:0]  out_priority;
        logic [OCC_W-1:0]   occupancy;
    } t_spq_rsp;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

>>> src/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted chain. On an insert it keeps its entry, takes
// the new entry or takes the entry of its left neighbor; on a removal it takes
// the entry of its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [PRIO_BITS-1:0]  i_new_prio,
    input  logic [TAG_BITS-1:0]   i_new_tag,
    input  logic                  i_left_greater,
    input  logic [PRIO_BITS-1:0]  i_left_prio,
    input  logic [TAG_BITS-1:0]   i_left_tag,
    input  logic [PRIO_BITS-1:0]  i_right_prio,
    input  logic [TAG_BITS-1:0]   i_right_tag,
    output logic                  o_greater,
    output logic [PRIO_BITS-1:0]  o_prio,
    output logic [TAG_BITS-1:0]   o_tag
);

    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] n_prio;
    logic [TAG_BITS-1:0]  n_tag;
    logic                 w_greater;

    // The new entry goes ahead of this one when this place is free or holds
    // a strictly lower priority, which keeps equal priorities in FIFO order.
    assign w_greater = !i_occupied || (i_new_prio > r_prio);

    // Select the entry this place holds after the request.
    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctl.insert && w_greater) begin
            if (i_left_greater) begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end else begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end
        end else if (i_ctl.remove) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    // Entry storage needs no reset: occupancy comes from the entry count.
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_greater = w_greater;
    assign o_prio    = r_prio;
    assign o_tag     = r_tag;

endmodule

>>> src/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded priority queue held as a chain of cells, highest priority at the
// head, equal priorities served first in, first out.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_req).
//   A request is an insert of a tag and priority or a removal of the head.
//   Each request yields exactly one response on the output channel
//   (o_out_valid, i_out_stall, o_out_rsp) with a status, the removed entry
//   on a successful removal (zero otherwise) and the occupancy afterwards.
//   Every cell compares the new priority with its own entry and shifts or
//   takes data from a neighbor in the same cycle, so its response is valid
//   in the cycle after acceptance, held in the single output register, and
//   one request per cycle is sustained while the receiver does not stall.
//   When the receiver stalls, the response is held and o_in_stall rises
//   only while the output register is full and stalled; a response that is
//   taken frees the register for a request in the same cycle.
//   Reset empties the queue and drops any pending response; entries are not
//   cleared, since a place is only read while it lies below the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spq_pkg::t_spq_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spq_pkg::t_spq_rsp o_out_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    spq_pkg::t_cell_ctl   w_ctl;
    logic [PRIO_BITS-1:0] w_new_prio;
    logic [TAG_BITS-1:0]  w_new_tag;
    logic [PRIO_BITS+spq_pkg::PRIO_W-1:0] w_prio_in_ext;
    logic [TAG_BITS+spq_pkg::TAG_W-1:0]   w_tag_in_ext;
    logic [PRIO_BITS+spq_pkg::PRIO_W-1:0] w_prio_out_ext;
    logic [TAG_BITS+spq_pkg::TAG_W-1:0]   w_tag_out_ext;
    logic [CNT_W+spq_pkg::OCC_W-1:0]      w_occ_ext;

    logic                 w_greater [DEPTH];
    logic [PRIO_BITS-1:0] w_prio    [DEPTH];
    logic [TAG_BITS-1:0]  w_tag     [DEPTH];

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    spq_pkg::t_spq_rsp    r_rsp;
    spq_pkg::t_spq_rsp    n_rsp;

    // A request is taken whenever the output register is free or draining.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // Cell commands only for requests that are not refused.
    assign w_ctl.insert = w_accept && (i_in_req.req_type == spq_pkg::REQ_INSERT) && !w_full;
    assign w_ctl.remove = w_accept && (i_in_req.req_type == spq_pkg::REQ_REMOVE) && !w_empty;

    // Resize the request fields to the storage widths.
    assign w_prio_in_ext = {{PRIO_BITS{1'b0}}, i_in_req.priority_req};
    assign w_tag_in_ext  = {{TAG_BITS{1'b0}}, i_in_req.payload};
    assign w_new_prio    = w_prio_in_ext[PRIO_BITS-1:0];
    assign w_new_tag     = w_tag_in_ext[TAG_BITS-1:0];

    // Chain of cells, head at place zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_left_greater;
        logic [PRIO_BITS-1:0] w_left_prio;
        logic [TAG_BITS-1:0]  w_left_tag;
        logic [PRIO_BITS-1:0] w_right_prio;
        logic [TAG_BITS-1:0]  w_right_tag;
        logic                 w_occupied;

        if (g == 0) begin : g_head
            assign w_left_greater = 1'b0;
            assign w_left_prio    = '0;
            assign w_left_tag     = '0;
        end else begin : g_mid
            assign w_left_greater = w_greater[g-1];
            assign w_left_prio    = w_prio[g-1];
            assign w_left_tag     = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_prio = '0;
            assign w_right_tag  = '0;
        end else begin : g_body
            assign w_right_prio = w_prio[g+1];
            assign w_right_tag  = w_tag[g+1];
        end

        assign w_occupied = (r_count > CNT_W'(g));

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_occupied     (w_occupied),
            .i_new_prio     (w_new_prio),
            .i_new_tag      (w_new_tag),
            .i_left_greater (w_left_greater),
            .i_left_prio    (w_left_prio),
            .i_left_tag     (w_left_tag),
            .i_right_prio   (w_right_prio),
            .i_right_tag    (w_right_tag),
            .o_greater      (w_greater[g]),
            .o_prio         (w_prio[g]),
            .o_tag          (w_tag[g])
        );
    end

    // Entry count after the request.
    always_comb begin
        n_count = r_count;
        if (w_ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Resize head entry and count to the response field widths.
    assign w_prio_out_ext = {{spq_pkg::PRIO_W{1'b0}}, w_prio[0]};
    assign w_tag_out_ext  = {{spq_pkg::TAG_W{1'b0}}, w_tag[0]};
    assign w_occ_ext      = {{spq_pkg::OCC_W{1'b0}}, n_count};

    // Build the response for the accepted request.
    always_comb begin
        n_rsp              = r_rsp;
        n_rsp.status       = spq_pkg::ST_DONE;
        n_rsp.out_payload  = '0;
        n_rsp.out_priority = '0;
        n_rsp.occupancy    = w_occ_ext[spq_pkg::OCC_W-1:0];
        if (i_in_req.req_type == spq_pkg::REQ_INSERT) begin
            if (w_full) begin
                n_rsp.status = spq_pkg::ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_rsp.status = spq_pkg::ST_EMPTY;
            end else begin
                n_rsp.out_payload  = w_tag_out_ext[spq_pkg::TAG_W-1:0];
                n_rsp.out_priority = w_prio_out_ext[spq_pkg::PRIO_W-1:0];
            end
        end
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A successful insert raises the count by one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not raise the count");

    // A removal from an empty queue is reported as such.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_req.req_type == spq_pkg::REQ_REMOVE) && w_empty)
        |=> (o_out_valid && (o_out_rsp.status == spq_pkg::ST_EMPTY)
             && (o_out_rsp.occupancy == '0)))
        else $error("empty removal not reported");

    // A response just accepted reports the count that the queue now holds.
    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_out_rsp.occupancy == $past(w_occ_ext[spq_pkg::OCC_W-1:0])))
        else $error("reported occupancy differs from count");

endmodule

>>> test/sorted_priority_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Sends insert and removal requests to the queue, predicts every response
// with a behavioral copy of the sorted queue, and compares each response
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;

    localparam int QUEUE_DEPTH = 16;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 20000;

    // Ways of choosing the priority of an inserted entry.
    typedef enum int {
        PRIO_ANY,
        PRIO_FEW,
        PRIO_EXTREME,
        PRIO_TOP
    } t_prio_mix;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    spq_pkg::t_spq_req i_in_req    = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    spq_pkg::t_spq_rsp o_out_rsp;

    // Predicted queue contents, head at index 0.
    logic [spq_pkg::PRIO_W-1:0] held_prio [QUEUE_DEPTH];
    logic [spq_pkg::TAG_W-1:0]  held_tag  [QUEUE_DEPTH];
    int                         held_count = 0;

    // Responses predicted for accepted requests, oldest first.
    spq_pkg::t_spq_rsp pending_rsp[$];

    // Traffic shaping, set by the test tasks.
    int gap_max     = 0;
    int stall_level = 0;
    int burst_left  = 0;
    int holds_asked = 0;

    // Run statistics.
    int error_count       = 0;
    int responses_checked = 0;
    int n_inserts         = 0;
    int n_removals        = 0;
    int n_refused_full    = 0;
    int n_refused_empty   = 0;

    sorted_priority_queue_unit #(
        .DEPTH     (QUEUE_DEPTH),
        .PRIO_BITS (spq_pkg::PRIO_W),
        .TAG_BITS  (spq_pkg::TAG_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always #10 i_clk = ~i_clk;

    // Counts one mismatch and prints its line while no more than 40 have been seen.
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 40) begin
            $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
    endtask

    // Applies one request to the predicted queue and returns its response.
    function automatic spq_pkg::t_spq_rsp apply_request(input spq_pkg::t_spq_req req);
        spq_pkg::t_spq_rsp rsp;
        int                pos;
        rsp = '0;
        rsp.status = spq_pkg::ST_DONE;
        if (req.req_type == spq_pkg::REQ_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                rsp.status = spq_pkg::ST_FULL;
                n_refused_full++;
            end else begin
                // Entries of lower priority move back; equal ones stay ahead.
                pos = held_count;
                while (pos > 0 && held_prio[pos-1] < req.priority_req) begin
                    held_prio[pos] = held_prio[pos-1];
                    held_tag[pos]  = held_tag[pos-1];
                    pos--;
                end
                held_prio[pos] = req.priority_req;
                held_tag[pos]  = req.payload;
                held_count++;
                n_inserts++;
            end
        end else begin
            if (held_count == 0) begin
                rsp.status = spq_pkg::ST_EMPTY;
                n_refused_empty++;
            end else begin
                rsp.out_payload  = held_tag[0];
                rsp.out_priority = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_prio[i-1] = held_prio[i];
                    held_tag[i-1]  = held_tag[i];
                end
                held_count--;
                n_removals++;
            end
        end
        rsp.occupancy = spq_pkg::OCC_W'(held_count);
        return rsp;
    endfunction

    function automatic spq_pkg::t_spq_req make_insert(input logic [spq_pkg::TAG_W-1:0] tag,
                                                      input logic [spq_pkg::PRIO_W-1:0] prio);
        spq_pkg::t_spq_req req;
        req.req_type     = spq_pkg::REQ_INSERT;
        req.payload      = tag;
        req.priority_req = prio;
        return req;
    endfunction

    // Removal fields other than the kind carry junk that must be ignored.
    function automatic spq_pkg::t_spq_req make_remove();
        spq_pkg::t_spq_req req;
        req.req_type     = spq_pkg::REQ_REMOVE;
        req.payload      = spq_pkg::TAG_W'($urandom);
        req.priority_req = spq_pkg::PRIO_W'($urandom);
        return req;
    endfunction

    function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority(input t_prio_mix mix);
        case (mix)
            PRIO_ANY:     return spq_pkg::PRIO_W'($urandom);
            PRIO_FEW:     return spq_pkg::PRIO_W'($urandom_range(3, 0));
            PRIO_EXTREME: return ($urandom_range(1, 0) != 0) ? '1 : '0;
            default:      return '1 - spq_pkg::PRIO_W'($urandom_range(5, 0));
        endcase
    endfunction

    function automatic logic [spq_pkg::TAG_W-1:0] pick_tag();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return spq_pkg::TAG_W'($urandom);
        endcase
    endfunction

    // Offers one request, possibly after a gap, and waits until it is taken.
    task automatic send_request(input spq_pkg::t_spq_req req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_rsp.push_back(apply_request(req));
    endtask

    // Stops offering requests until every predicted response has arrived.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_rsp.size() != 0);
    endtask

    // Removal from an empty queue, field extremes, ties at both ends of the
    // priority range and a middle priority, then removal until empty again.
    task automatic test_empty_and_extremes();
        gap_max     = 0;
        stall_level = 0;
        send_request(make_remove());
        send_request(make_insert(16'h0000, 8'h00));
        send_request(make_insert(16'hFFFF, 8'hFF));
        send_request(make_insert(16'h1234, 8'hFF));
        send_request(make_insert(16'h5555, 8'h00));
        send_request(make_insert(16'h00A5, 8'h80));
        repeat (5) send_request(make_remove());
        send_request(make_remove());
        wait_for_drain();
    endtask

    // Fills the queue, knocks on it while full, then empties it past the end.
    task automatic test_fill_and_drain();
        logic [spq_pkg::PRIO_W-1:0] prio;
        for (int round = 0; round < 2; round++) begin
            gap_max     = round * 3;
            stall_level = round * 4;
            for (int n = 0; n < QUEUE_DEPTH; n++) begin
                // The first round uses one priority so the order is pure arrival.
                prio = (round == 0) ? 8'h42 : pick_priority(PRIO_ANY);
                send_request(make_insert(pick_tag(), prio));
            end
            repeat (2) send_request(make_insert(pick_tag(), pick_priority(PRIO_ANY)));
            send_request(make_remove());
            send_request(make_insert(pick_tag(), pick_priority(PRIO_FEW)));
            repeat (QUEUE_DEPTH + 1) send_request(make_remove());
            wait_for_drain();
        end
    endtask

    // Random traffic in phases whose insert share drives the queue between
    // empty and full, with varying priority spreads, gaps and stalls.
    task automatic test_random_traffic();
        int        insert_pct;
        t_prio_mix mix;
        for (int phase = 0; phase < 13; phase++) begin
            case ($urandom_range(4, 0))
                0:       insert_pct = 90;
                1:       insert_pct = 70;
                2:       insert_pct = 50;
                3:       insert_pct = 30;
                default: insert_pct = 10;
            endcase
            mix = t_prio_mix'($urandom_range(3, 0));
            // Every third phase runs with both sides at full speed.
            if (phase % 3 == 0) begin
                gap_max     = 0;
                stall_level = 0;
            end else begin
                gap_max     = $urandom_range(6, 0);
                stall_level = $urandom_range(10, 1);
            end
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(99, 0) < insert_pct) begin
                    send_request(make_insert(pick_tag(), pick_priority(mix)));
                end else begin
                    send_request(make_remove());
                end
            end
            if (phase % 4 == 3) begin
                wait_for_drain();
            end
        end
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the response register fills and the input channel must stall.
    task automatic test_output_backpressure();
        gap_max     = 0;
        stall_level = 0;
        for (int run = 0; run < 2; run++) begin
            holds_asked++;
            for (int n = 0; n < 30; n++) begin
                if ($urandom_range(99, 0) < 75) begin
                    send_request(make_insert(pick_tag(), pick_priority(PRIO_ANY)));
                end else begin
                    send_request(make_remove());
                end
            end
            wait_for_drain();
        end
    endtask

    // Receiver stall pattern: alternating free and stalled runs, plus long
    // hold-offs counted here when a test asks for one.
    always @(posedge i_clk) begin : receiver_stall
        int holds_served = 0;
        int hold_left    = 0;
        int run_left     = 0;
        bit stalling     = 1'b0;
        if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_level == 0) begin
            i_out_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                stalling = !stalling;
                run_left = stalling ? $urandom_range(stall_level, 1) : $urandom_range(8, 1);
            end
            run_left--;
            i_out_stall <= stalling;
        end
    end

    // Compares every accepted response with the oldest prediction.
    always @(posedge i_clk) begin : response_check
        spq_pkg::t_spq_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("response with nothing outstanding, status", 
                                int'(o_out_rsp.status), 0);
            end else begin
                want = pending_rsp.pop_front();
                responses_checked++;
                if (o_out_rsp.status != want.status) begin
                    report_mismatch("status", int'(o_out_rsp.status), int'(want.status));
                end
                if (o_out_rsp.out_payload != want.out_payload) begin
                    report_mismatch("out_payload", int'(o_out_rsp.out_payload),
                                    int'(want.out_payload));
                end
                if (o_out_rsp.out_priority != want.out_priority) begin
                    report_mismatch("out_priority", int'(o_out_rsp.out_priority),
                                    int'(want.out_priority));
                end
                if (o_out_rsp.occupancy != want.occupancy) begin
                    report_mismatch("occupancy", int'(o_out_rsp.occupancy),
                                    int'(want.occupancy));
                end
            end
        end
    end

    // Main sequence: reset, the tests in turn, then the final verdict.
    initial begin : main_sequence
        int wait_cycles;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_extremes();
        test_fill_and_drain();
        test_random_traffic();
        test_output_backpressure();

        // Collect anything still in flight, then watch for strays.
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge i_clk);
            wait_cycles++;
        end while (pending_rsp.size() != 0 && wait_cycles < DRAIN_LIMIT);
        if (pending_rsp.size() != 0) begin
            report_mismatch("responses never delivered", 0, pending_rsp.size());
        end
        repeat (5) @(posedge i_clk);

        $display("Checked %0d responses: %0d inserts, %0d removals, %0d refused full, %0d %s",
                 responses_checked, n_inserts, n_removals, n_refused_full,
                 n_refused_empty, "refused empty");
        $display("Traffic included ties, full and empty queues, gaps, stalls and long holds.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : run_limit
        #5_000_000;
        $display("Timeout: the run did not finish in time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_unit.sv
test/sorted_priority_queue_unit_test.sv
